FILE: hw/rtl/sine_commutation_stepper_core_defines.svh
// Assertion helpers for the commutation stepper.
`ifndef SINE_COMMUTATION_STEPPER_CORE_DEFINES_SVH
`define SINE_COMMUTATION_STEPPER_CORE_DEFINES_SVH

// Same-cycle implication.
`define SCS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/scs_pkg.sv
package scs_pkg;

  localparam int unsigned TABLE_SIZE = 1024;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned PWM_PERIOD = 1023;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned SPEED_W    = 16;
  localparam int unsigned CMD_DEPTH  = 2;
  localparam int unsigned RES_DEPTH  = 2;

  localparam logic [SPEED_W-1:0] BASIC_SPEED_RST = SPEED_W'(360);
  localparam logic [IDX_W-1:0]   IDX_B_RST       = IDX_W'(TABLE_SIZE / 3);
  localparam logic [IDX_W-1:0]   IDX_C_RST       = IDX_W'(2 * (TABLE_SIZE / 3));

  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;
  localparam logic [63:0] ONE_Q62     = 64'h4000000000000000;
  localparam logic [DUTY_W-1:0] DUTY_MAX = '1;

  typedef struct packed {
    logic               direction;
    logic [SPEED_W-1:0] speed;
  } in_word_t;

  typedef struct packed {
    logic [DUTY_W-1:0] phase_a_duty;
    logic [DUTY_W-1:0] phase_b_duty;
    logic [DUTY_W-1:0] phase_c_duty;
  } out_word_t;

  typedef struct packed {
    logic             back;
    logic [IDX_W-1:0] step;
  } cmd_t;

  typedef logic [TABLE_SIZE-1:0][DUTY_W-1:0] rom_t;

  // (a*b) >> sh, low 64 bits
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> sh;
    return p[63:0];
  endfunction

  // Q62 Taylor series, 0 <= x <= pi/2
  function automatic logic [63:0] sin_q62(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    int unsigned n;
    x2   = mul_shr(x, x, 62);
    term = x;
    sum  = x;
    for (n = 1; n <= 15; n++) begin
      term = mul_shr(term, x2, 62) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  function automatic logic [DUTY_W-1:0] rom_entry(int unsigned i);
    logic [63:0] k;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] s;
    logic [63:0] v;
    int          num;
    k   = 64'((i + 1) % TABLE_SIZE);
    num = 9;
    if (((64'd12 * k) % 64'(TABLE_SIZE)) == 64'd0) begin
      case ((64'd12 * k) / 64'(TABLE_SIZE)) inside
        64'd0, 64'd6:  num = 0;
        64'd3:         num = 2;
        64'd9:         num = -2;
        64'd1, 64'd5:  num = 1;
        64'd7, 64'd11: num = -1;
        default:       num = 9;
      endcase
    end
    if (num != 9) begin
      v = (64'(2 + num) * 64'(PWM_PERIOD)) / 64'd4;
    end else begin
      q = (64'd4 * k) / 64'(TABLE_SIZE);
      r = 64'd4 * k - q * 64'(TABLE_SIZE);
      if (q[0]) begin
        r = 64'(TABLE_SIZE) - r;
      end
      x = (HALF_PI_Q62 / 64'(TABLE_SIZE)) * r
          + ((HALF_PI_Q62 % 64'(TABLE_SIZE)) * r) / 64'(TABLE_SIZE);
      s = sin_q62(x);
      if (s > ONE_Q62) begin
        s = ONE_Q62;
      end
      s = (q >= 64'd2) ? ONE_Q62 - s : ONE_Q62 + s;
      v = mul_shr(s, 64'(PWM_PERIOD), 63);
    end
    if (v > 64'(DUTY_MAX)) begin
      v = 64'(DUTY_MAX);
    end
    return v[DUTY_W-1:0];
  endfunction

  function automatic rom_t build_sine_rom();
    rom_t        t;
    int unsigned i;
    for (i = 0; i < TABLE_SIZE; i++) begin
      t[i] = rom_entry(i);
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_sine_rom();

endpackage

FILE: hw/rtl/sine_commutation_stepper_core.sv
// Three-phase sine commutation stepper. Push one control tick (direction, speed) per
// word; each tick yields either no result or one word of three PWM compare values read
// from a sine ROM at the phase A/B/C indices, after which the indices step forward or
// back. Speed zero is dropped. A nonzero tick holds the input while the front end is
// busy: one with the same speed as the last one goes straight to evaluation, and a new
// nonzero speed first runs the 16-step restoring divider that recomputes hold count and
// stride. Each update then passes back end states RDA, RDB and RDC, three reads through
// the single ROM port, then PUSH; small command and result queues let input and output
// stall independently. basic_speed resets to 360 (0 acts as 1), used at next speed change.
module sine_commutation_stepper_core
  import scs_pkg::*;
#(
  parameter int unsigned CmdDepth = CMD_DEPTH,
  parameter int unsigned ResDepth = RES_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  in_word_t           in_word_i,
  output logic               empty,
  input  logic               pop,
  output out_word_t          out_word_o,
  input  logic               cfg_we_i,
  input  logic [SPEED_W-1:0] cfg_wdata_i
);

  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t      cmd_wr, cmd_rd;
  logic      res_push, res_full;
  out_word_t res_wr;

  scs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_push_o  (cmd_push),
    .cmd_full_i  (cmd_full),
    .cmd_o       (cmd_wr)
  );

  scs_queue #(
    .Depth (CmdDepth),
    .Width ($bits(cmd_t))
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .full_o  (cmd_full),
    .wdata_i (cmd_wr),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_rd)
  );

  scs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .cmd_i       (cmd_rd),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (res_wr)
  );

  scs_queue #(
    .Depth (ResDepth),
    .Width ($bits(out_word_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_wr),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (out_word_o)
  );

endmodule

FILE: hw/rtl/scs_queue.sv
module scs_queue
  import scs_pkg::*;
#(
  parameter int unsigned Depth = CMD_DEPTH,
  parameter int unsigned Width = $bits(cmd_t)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hw/rtl/scs_front.sv
module scs_front
  import scs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  output logic               full_o,
  input  in_word_t           in_word_i,
  input  logic               cfg_we_i,
  input  logic [SPEED_W-1:0] cfg_wdata_i,
  output logic               cmd_push_o,
  input  logic               cmd_full_i,
  output cmd_t               cmd_o
);

  localparam logic [1:0] FS_IDLE = 2'd0;
  localparam logic [1:0] FS_DIV  = 2'd1;
  localparam logic [1:0] FS_EVAL = 2'd2;

  localparam int unsigned DivCntW = $clog2(SPEED_W);
  localparam logic [DivCntW-1:0] DivLast = DivCntW'(SPEED_W - 1);

  logic [1:0]         state_q;
  logic [SPEED_W-1:0] basic_q, last_speed_q, hold_q, tick_q, stride_q;
  logic               dir_q, slow_q;
  logic [SPEED_W-1:0] speed_q, divisor_q, rem_q, quo_q;
  logic [DivCntW-1:0] cnt_q;

  logic [SPEED_W-1:0] base;
  logic               accept, in_slow;
  logic [SPEED_W:0]   rem_sh;
  logic               rem_ge;
  logic [SPEED_W-1:0] rem_nx, quo_nx;

  assign base    = (basic_q == '0) ? SPEED_W'(1) : basic_q;
  assign full_o  = (state_q != FS_IDLE) || cmd_full_i;
  assign accept  = push_i && !full_o;
  assign in_slow = (in_word_i.speed < base);

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_q, quo_q[SPEED_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, divisor_q});
  assign rem_nx = rem_ge ? SPEED_W'(rem_sh - {1'b0, divisor_q}) : rem_sh[SPEED_W-1:0];
  assign quo_nx = {quo_q[SPEED_W-2:0], rem_ge};

  assign cmd_push_o = (state_q == FS_EVAL) && (tick_q >= hold_q);
  assign cmd_o.back = dir_q;
  assign cmd_o.step = IDX_W'(stride_q % TABLE_SIZE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FS_IDLE;
      basic_q      <= BASIC_SPEED_RST;
      last_speed_q <= '0;
      hold_q       <= '0;
      tick_q       <= '0;
      stride_q     <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        basic_q <= cfg_wdata_i;
      end
      unique case (state_q)
        FS_IDLE: begin
          if (accept && (in_word_i.speed != '0)) begin
            cnt_q   <= '0;
            state_q <= (in_word_i.speed != last_speed_q) ? FS_DIV : FS_EVAL;
          end
        end
        FS_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) begin
            last_speed_q <= speed_q;
            state_q      <= FS_EVAL;
            if (slow_q) begin
              hold_q   <= quo_nx - 1'b1;
              stride_q <= SPEED_W'(1);
            end else begin
              hold_q   <= '0;
              stride_q <= quo_nx;
            end
          end
        end
        FS_EVAL: begin
          tick_q  <= (tick_q < hold_q) ? tick_q + 1'b1 : '0;
          state_q <= FS_IDLE;
        end
        default: state_q <= FS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == FS_IDLE) && accept) begin
      dir_q     <= in_word_i.direction;
      speed_q   <= in_word_i.speed;
      slow_q    <= in_slow;
      divisor_q <= in_slow ? in_word_i.speed : base;
      quo_q     <= in_slow ? base : in_word_i.speed;
      rem_q     <= '0;
    end else if (state_q == FS_DIV) begin
      rem_q <= rem_nx;
      quo_q <= quo_nx;
    end
  end

endmodule

FILE: hw/rtl/scs_back.sv
module scs_back
  import scs_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_empty_i,
  output logic      cmd_pop_o,
  input  cmd_t      cmd_i,
  output logic      res_push_o,
  input  logic      res_full_i,
  output out_word_t res_o
);

  localparam logic [2:0] BS_IDLE = 3'd0;
  localparam logic [2:0] BS_RDA  = 3'd1;
  localparam logic [2:0] BS_RDB  = 3'd2;
  localparam logic [2:0] BS_RDC  = 3'd3;
  localparam logic [2:0] BS_PUSH = 3'd4;

  localparam int unsigned SumW = IDX_W + 1;

  logic [2:0]        state_q;
  logic [IDX_W-1:0]  idx_a_q, idx_b_q, idx_c_q;
  logic              back_q;
  logic [IDX_W-1:0]  step_q;
  logic [IDX_W-1:0]  rom_addr;
  logic [DUTY_W-1:0] rom_q, duty_a_q, duty_b_q;

  function automatic logic [IDX_W-1:0] advance(logic [IDX_W-1:0] cur,
                                               logic [IDX_W-1:0] step,
                                               logic             bck);
    logic [SumW-1:0] s;
    if (bck) begin
      s = {1'b0, cur} + SumW'(TABLE_SIZE) - {1'b0, step};
    end else begin
      s = {1'b0, cur} + {1'b0, step};
    end
    if (s >= SumW'(TABLE_SIZE)) begin
      s = s - SumW'(TABLE_SIZE);
    end
    return s[IDX_W-1:0];
  endfunction

  assign cmd_pop_o  = (state_q == BS_IDLE) && !cmd_empty_i && !res_full_i;
  assign res_push_o = (state_q == BS_PUSH);

  always_comb begin
    unique case (state_q)
      BS_RDA:  rom_addr = idx_a_q;
      BS_RDB:  rom_addr = idx_b_q;
      default: rom_addr = idx_c_q;
    endcase
  end

  always_comb begin
    res_o.phase_a_duty = duty_a_q;
    res_o.phase_b_duty = duty_b_q;
    res_o.phase_c_duty = rom_q;
  end

  // single-port sine ROM, registered read
  always_ff @(posedge clk_i) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      back_q <= cmd_i.back;
      step_q <= cmd_i.step;
    end
    if (state_q == BS_RDB) begin
      duty_a_q <= rom_q;
    end
    if (state_q == BS_RDC) begin
      duty_b_q <= rom_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BS_IDLE;
      idx_a_q <= '0;
      idx_b_q <= IDX_B_RST;
      idx_c_q <= IDX_C_RST;
    end else begin
      unique case (state_q)
        BS_IDLE: if (cmd_pop_o) state_q <= BS_RDA;
        BS_RDA:  state_q <= BS_RDB;
        BS_RDB:  state_q <= BS_RDC;
        BS_RDC:  state_q <= BS_PUSH;
        BS_PUSH: begin
          idx_a_q <= advance(idx_a_q, step_q, back_q);
          idx_b_q <= advance(idx_b_q, step_q, back_q);
          idx_c_q <= advance(idx_c_q, step_q, back_q);
          state_q <= BS_IDLE;
        end
        default: state_q <= BS_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/scs_checker.sv
`include "sine_commutation_stepper_core_defines.svh"

module scs_checker
  import scs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      push,
  input logic      full,
  input in_word_t  in_word_i,
  input logic      empty,
  input logic      pop,
  input out_word_t out_word_o
);

  `SCS_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, !empty && !pop, $stable(out_word_o), "result word changed while waiting")
  `SCS_ASSERT_IMPL(a_empty_by_pop, clk_i, rst_ni, $rose(empty), $past(pop), "result queue drained without pop")
  `SCS_ASSERT_NEXT(a_zero_no_stall, clk_i, rst_ni, push && !full && (in_word_i.speed == '0), !full, "zero-speed tick stalled input")
  `SCS_ASSERT_NEXT(a_tick_busy, clk_i, rst_ni, push && !full && (in_word_i.speed != '0), full, "nonzero tick did not occupy front end")

endmodule

bind sine_commutation_stepper_core scs_checker u_scs_checker (.*);
